FILE: hw/rtl/vbs_pkg.sv
`timescale 1ns / 1ps
package vbs_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = 10;
  localparam int CNT_W        = 11;
  localparam int CRD_W        = 16;
  localparam int SUM_W        = 26;
  localparam int VTX_W        = 3 * CRD_W;
  localparam int OPND_W       = 44;
  localparam int DVS_W        = 11;
  localparam int SQ_W         = 34;
  localparam int TOT_W        = 44;
  localparam int RT_W         = 17;
  localparam int ITER_W       = 6;
  localparam int OUT_DATA_W   = 200;

  localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(OPND_W - 1);
  localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(RT_W - 1);

  // sequencer states
  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_CDIV_G = 4'd1;
  localparam logic [3:0] ST_CDIV_W = 4'd2;
  localparam logic [3:0] ST_RD     = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_ACC    = 4'd5;
  localparam logic [3:0] ST_MDIV_G = 4'd6;
  localparam logic [3:0] ST_MDIV_W = 4'd7;
  localparam logic [3:0] ST_SQ_G   = 4'd8;
  localparam logic [3:0] ST_SQ_W   = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  typedef struct packed {
    logic              start;
    logic              sqrt;
    logic [OPND_W-1:0] opnd;
    logic [DVS_W-1:0]  dvs;
  } itu_req_t;

  typedef struct packed {
    logic              done;
    logic [OPND_W-1:0] res;
  } itu_rsp_t;

endpackage

FILE: hw/rtl/vbs_ram.sv
`timescale 1ns / 1ps
module vbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/vbs_itu.sv
`timescale 1ns / 1ps
// Shared iterative unit: restoring divide (one quotient bit per cycle)
// or digit-by-digit floor square root (one root bit per cycle).
module vbs_itu (
  input  logic               clk,
  input  logic               rst_n,
  input  vbs_pkg::itu_req_t  req,
  output vbs_pkg::itu_rsp_t  rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic                              sqrt_r, sqrt_nxt;
  logic [vbs_pkg::ITER_W-1:0]        cnt_r, cnt_nxt;
  logic [vbs_pkg::OPND_W-1:0]        opnd_r, opnd_nxt;
  logic [vbs_pkg::OPND_W-1:0]        quo_r, quo_nxt;
  logic [19:0]                       rem_r, rem_nxt;
  logic [vbs_pkg::DVS_W-1:0]         dvs_r, dvs_nxt;

  logic [vbs_pkg::DVS_W:0]           div_sh;
  logic                              div_ge;
  logic [19:0]                       sq_sh, sq_trial;
  logic                              sq_ge;
  logic [vbs_pkg::ITER_W-1:0]        last;

  always_comb begin
    div_sh   = {rem_r[vbs_pkg::DVS_W-1:0], opnd_r[vbs_pkg::OPND_W-1]};
    div_ge   = div_sh >= {1'b0, dvs_r};
    sq_sh    = {rem_r[17:0], opnd_r[vbs_pkg::SQ_W-1 -: 2]};
    sq_trial = {quo_r[17:0], 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    last     = sqrt_r ? vbs_pkg::SQRT_LAST : vbs_pkg::DIV_LAST;

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    opnd_nxt = opnd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.sqrt;
      cnt_nxt  = '0;
      opnd_nxt = req.opnd;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = req.dvs;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (sqrt_r) begin
        rem_nxt  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
        quo_nxt  = {quo_r[vbs_pkg::OPND_W-2:0], sq_ge};
        opnd_nxt = opnd_r << 2;
      end else begin
        rem_nxt  = {8'b0, (div_ge ? (div_sh - {1'b0, dvs_r}) : div_sh)};
        quo_nxt  = {quo_r[vbs_pkg::OPND_W-2:0], div_ge};
        opnd_nxt = opnd_r << 1;
      end
      if (cnt_r == last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sqrt_r <= sqrt_nxt;
    cnt_r  <= cnt_nxt;
    opnd_r <= opnd_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = quo_r;

endmodule

FILE: hw/rtl/vertex_bounds_and_spread.sv
`timescale 1ns / 1ps
// Loading takes one vertex per cycle. After the last vertex the block is busy
// with the three centroid divides, the store pass (read, three squares, last
// add, accumulate for each vertex held), the mean divide and the three roots,
// all on one shared divide/root unit and one multiplier; the result then waits
// in the output register while the next set loads. rst_n is synchronous,
// active low, and clears the sequencer, vertex count and valid flags.
module vertex_bounds_and_spread (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // x_min, x_max, y_min, y_max, z_min, z_max, center_x, center_y, center_z
  // (16 bits each from bit 0), near_dist[160:144], far_dist[177:161],
  // mean_dist[194:178], zeros above
  output logic [199:0] out_tdata
);

  localparam int CW = vbs_pkg::CRD_W;

  logic [3:0]                    state_r, state_nxt;
  logic [1:0]                    ax_r, ax_nxt;
  logic [vbs_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [vbs_pkg::ADDR_W-1:0]    idx_r, idx_nxt;
  logic signed [CW-1:0]          mins_r [3], mins_nxt [3];
  logic signed [CW-1:0]          maxs_r [3], maxs_nxt [3];
  logic signed [vbs_pkg::SUM_W-1:0] sums_r [3], sums_nxt [3];
  logic signed [CW-1:0]          cen_r [3], cen_nxt [3];
  logic [vbs_pkg::SQ_W-1:0]      prod_r, prod_nxt;
  logic [vbs_pkg::SQ_W-1:0]      d2_r, d2_nxt;
  logic [vbs_pkg::SQ_W-1:0]      near_r, near_nxt;
  logic [vbs_pkg::SQ_W-1:0]      far_r, far_nxt;
  logic [vbs_pkg::SQ_W-1:0]      mean_r, mean_nxt;
  logic [vbs_pkg::TOT_W-1:0]     total_r, total_nxt;
  logic [vbs_pkg::RT_W-1:0]      root_r [3], root_nxt [3];
  logic                          out_valid_r, out_valid_nxt;
  logic [199:0]                  out_data_r, out_data_nxt;

  logic                          in_acc;
  logic                          ram_we, ram_re;
  logic [vbs_pkg::VTX_W-1:0]     ram_rdata;
  vbs_pkg::itu_req_t             itu_req;
  vbs_pkg::itu_rsp_t             itu_rsp;

  logic signed [CW-1:0]          in_c [3];
  logic signed [CW-1:0]          st_c;
  logic signed [CW-1:0]          cen_c;
  logic signed [vbs_pkg::SUM_W-1:0] sum_c;
  logic signed [CW:0]            dlt;
  logic [CW:0]                   dmag;
  logic                          sum_neg;
  logic [vbs_pkg::SUM_W-1:0]     sum_mag;
  logic [CW-1:0]                 q16;

  assign in_tready  = (state_r == vbs_pkg::ST_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign ram_we     = in_acc && !count_r[vbs_pkg::CNT_W-1];
  assign ram_re     = (state_r == vbs_pkg::ST_RD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  vbs_ram #(.WIDTH(vbs_pkg::VTX_W), .DEPTH(vbs_pkg::MAX_VERTICES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[vbs_pkg::ADDR_W-1:0]),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  vbs_itu u_itu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (itu_req),
    .rsp   (itu_rsp)
  );

  // per-vertex distance term for the current axis
  always_comb begin
    in_c[0] = in_tdata[15:0];
    in_c[1] = in_tdata[31:16];
    in_c[2] = in_tdata[47:32];
    case (ax_r)
      2'd0: begin
        st_c  = ram_rdata[15:0];
        cen_c = cen_r[0];
        sum_c = sums_r[0];
      end
      2'd1: begin
        st_c  = ram_rdata[31:16];
        cen_c = cen_r[1];
        sum_c = sums_r[1];
      end
      default: begin
        st_c  = ram_rdata[47:32];
        cen_c = cen_r[2];
        sum_c = sums_r[2];
      end
    endcase
    dlt     = {st_c[CW-1], st_c} - {cen_c[CW-1], cen_c};
    dmag    = dlt[CW] ? (~dlt + 1'b1) : dlt;
    sum_neg = sum_c[vbs_pkg::SUM_W-1];
    sum_mag = sum_neg ? (~sum_c + 1'b1) : sum_c;
    q16     = itu_rsp.res[CW-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    mins_nxt      = mins_r;
    maxs_nxt      = maxs_r;
    sums_nxt      = sums_r;
    cen_nxt       = cen_r;
    prod_nxt      = prod_r;
    d2_nxt        = d2_r;
    near_nxt      = near_r;
    far_nxt       = far_r;
    mean_nxt      = mean_r;
    total_nxt     = total_r;
    root_nxt      = root_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    itu_req       = '0;

    case (state_r)
      vbs_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (!count_r[vbs_pkg::CNT_W-1]) begin
            for (int a = 0; a < 3; a++) begin
              if (in_c[a] < mins_r[a]) mins_nxt[a] = in_c[a];
              if (in_c[a] > maxs_r[a]) maxs_nxt[a] = in_c[a];
              sums_nxt[a] = sums_r[a] + vbs_pkg::SUM_W'(in_c[a]);
            end
            count_nxt = count_r + 1'b1;
          end
          if (in_tlast) begin
            ax_nxt    = 2'd0;
            state_nxt = vbs_pkg::ST_CDIV_G;
          end
        end
      end
      vbs_pkg::ST_CDIV_G: begin
        itu_req.start = 1'b1;
        itu_req.opnd  = vbs_pkg::OPND_W'(sum_mag);
        itu_req.dvs   = count_r;
        state_nxt     = vbs_pkg::ST_CDIV_W;
      end
      vbs_pkg::ST_CDIV_W: begin
        if (itu_rsp.done) begin
          cen_nxt[ax_r] = sum_neg ? (~q16 + 1'b1) : q16;
          if (ax_r == 2'd2) begin
            idx_nxt   = '0;
            near_nxt  = '1;
            far_nxt   = '0;
            total_nxt = '0;
            state_nxt = vbs_pkg::ST_RD;
          end else begin
            ax_nxt    = ax_r + 1'b1;
            state_nxt = vbs_pkg::ST_CDIV_G;
          end
        end
      end
      vbs_pkg::ST_RD: begin
        ax_nxt    = 2'd0;
        state_nxt = vbs_pkg::ST_MUL;
      end
      vbs_pkg::ST_MUL: begin
        // square one axis per cycle, add the previous square
        prod_nxt = dmag * dmag;
        d2_nxt   = (ax_r == 2'd0) ? '0 : (d2_r + prod_r);
        if (ax_r == 2'd3) begin
          state_nxt = vbs_pkg::ST_ACC;
        end else begin
          ax_nxt = ax_r + 1'b1;
        end
      end
      vbs_pkg::ST_ACC: begin
        if (d2_r < near_r) near_nxt = d2_r;
        if (d2_r > far_r)  far_nxt  = d2_r;
        total_nxt = total_r + vbs_pkg::TOT_W'(d2_r);
        if ({1'b0, idx_r} == count_r - 1'b1) begin
          state_nxt = vbs_pkg::ST_MDIV_G;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = vbs_pkg::ST_RD;
        end
      end
      vbs_pkg::ST_MDIV_G: begin
        itu_req.start = 1'b1;
        itu_req.opnd  = total_r;
        itu_req.dvs   = count_r;
        state_nxt     = vbs_pkg::ST_MDIV_W;
      end
      vbs_pkg::ST_MDIV_W: begin
        if (itu_rsp.done) begin
          mean_nxt  = itu_rsp.res[vbs_pkg::SQ_W-1:0];
          ax_nxt    = 2'd0;
          state_nxt = vbs_pkg::ST_SQ_G;
        end
      end
      vbs_pkg::ST_SQ_G: begin
        itu_req.start = 1'b1;
        itu_req.sqrt  = 1'b1;
        case (ax_r)
          2'd0:    itu_req.opnd = vbs_pkg::OPND_W'(near_r);
          2'd1:    itu_req.opnd = vbs_pkg::OPND_W'(far_r);
          default: itu_req.opnd = vbs_pkg::OPND_W'(mean_r);
        endcase
        state_nxt = vbs_pkg::ST_SQ_W;
      end
      vbs_pkg::ST_SQ_W: begin
        if (itu_rsp.done) begin
          root_nxt[ax_r] = itu_rsp.res[vbs_pkg::RT_W-1:0];
          if (ax_r == 2'd2) begin
            state_nxt = vbs_pkg::ST_OUT;
          end else begin
            ax_nxt    = ax_r + 1'b1;
            state_nxt = vbs_pkg::ST_SQ_G;
          end
        end
      end
      vbs_pkg::ST_OUT: begin
        // wait for the output register, then clear the set
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, root_r[2], root_r[1], root_r[0],
                           cen_r[2], cen_r[1], cen_r[0],
                           maxs_r[2], mins_r[2], maxs_r[1], mins_r[1],
                           maxs_r[0], mins_r[0]};
          count_nxt = '0;
          for (int a = 0; a < 3; a++) begin
            mins_nxt[a] = {1'b0, {(CW-1){1'b1}}};
            maxs_nxt[a] = {1'b1, {(CW-1){1'b0}}};
            sums_nxt[a] = '0;
          end
          state_nxt = vbs_pkg::ST_LOAD;
        end
      end
      default: state_nxt = vbs_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vbs_pkg::ST_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        mins_r[a] <= {1'b0, {(CW-1){1'b1}}};
        maxs_r[a] <= {1'b1, {(CW-1){1'b0}}};
        sums_r[a] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      mins_r      <= mins_nxt;
      maxs_r      <= maxs_nxt;
      sums_r      <= sums_nxt;
    end
    ax_r       <= ax_nxt;
    idx_r      <= idx_nxt;
    cen_r      <= cen_nxt;
    prod_r     <= prod_nxt;
    d2_r       <= d2_nxt;
    near_r     <= near_nxt;
    far_r      <= far_nxt;
    mean_r     <= mean_nxt;
    total_r    <= total_nxt;
    root_r     <= root_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: hw/rtl/vbs_checker.sv
`timescale 1ns / 1ps
module vbs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [47:0]  in_tdata,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [199:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // the closing pass blocks new vertices
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("vertex accepted right after last");

  // box is ordered along x
  a_box_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[15:0]) <= $signed(out_tdata[31:16]))
    else $error("x_min above x_max");

  // nearest distance never exceeds farthest
  a_dist_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[160:144] <= out_tdata[177:161])
    else $error("near_dist above far_dist");

endmodule

bind vertex_bounds_and_spread vbs_checker u_vbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [15:0] px, py, pz;
    logic        last;
  } vertex_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [199:0] out_tdata;

  vertex_bounds_and_spread uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  vertex_t      pending_verts[$];
  logic [199:0] expected_stats[$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           hold_off = 600;
  int           send_gap = 0;
  int           recv_gap = 0;
  logic         in_taken = 1'b0;

  // shadow of the set being accumulated
  logic signed [15:0] set_x[$], set_y[$], set_z[$];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // store a vertex in the shadow set; on the last one compute the stats
  task automatic predict_stats(vertex_t v);
    longint mn[3], mx[3], sm[3], ctr[3], d;
    logic [63:0] nsq, fsq, tot, d2, rt;
    logic [199:0] r;
    int n;
    if (set_x.size() < vbs_pkg::MAX_VERTICES) begin
      set_x = {set_x, v.px}; set_y = {set_y, v.py}; set_z = {set_z, v.pz};
    end
    if (!v.last) return;
    n = set_x.size();
    for (int a = 0; a < 3; a++) begin
      mn[a] = 32767; mx[a] = -32768; sm[a] = 0;
    end
    for (int i = 0; i < n; i++) begin
      longint c[3];
      c[0] = set_x[i]; c[1] = set_y[i]; c[2] = set_z[i];
      for (int a = 0; a < 3; a++) begin
        if (c[a] < mn[a]) mn[a] = c[a];
        if (c[a] > mx[a]) mx[a] = c[a];
        sm[a] += c[a];
      end
    end
    for (int a = 0; a < 3; a++) ctr[a] = sm[a] / n;
    nsq = '1; fsq = 0; tot = 0;
    for (int i = 0; i < n; i++) begin
      longint c[3];
      c[0] = set_x[i]; c[1] = set_y[i]; c[2] = set_z[i];
      d2 = 0;
      for (int a = 0; a < 3; a++) begin
        d = c[a] - ctr[a];
        d2 += d * d;
      end
      if (d2 < nsq) nsq = d2;
      if (d2 > fsq) fsq = d2;
      tot += d2;
    end
    r = '0;
    for (int a = 0; a < 3; a++) begin
      r[32*a +: 16]      = mn[a][15:0];
      r[32*a + 16 +: 16] = mx[a][15:0];
      r[96 + 16*a +: 16] = ctr[a][15:0];
    end
    rt = isqrt(nsq);
    r[144 +: 17] = rt[16:0];
    rt = isqrt(fsq);
    r[161 +: 17] = rt[16:0];
    rt = isqrt(tot / n);
    r[178 +: 17] = rt[16:0];
    expected_stats = {expected_stats, r};
    set_x.delete(); set_y.delete(); set_z.delete();
  endtask

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  // driver: offers requests from the pending queue
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        void'(pending_verts.pop_front());
        send_gap = pick_gap();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_verts.size() > 0) begin
        in_tvalid <= 1'b1;
        {in_tdata, in_tlast} <= {pending_verts[0].pz, pending_verts[0].py,
                                 pending_verts[0].px, pending_verts[0].last};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: long hold-off after reset, then random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // monitor: predict on accepted input, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_tvalid && in_tready) begin
        vertex_t v;
        v.px = in_tdata[15:0]; v.py = in_tdata[31:16]; v.pz = in_tdata[47:32];
        v.last = in_tlast;
        predict_stats(v);
      end
      if (out_tvalid && out_tready) begin
        if (expected_stats.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          logic [199:0] e;
          e = expected_stats.pop_front();
          if (e !== out_tdata) begin
            errors++;
            if (errors <= 10)
              for (int f = 0; f < 12; f++)
                if (f < 9 ? e[16*f +: 16] !== out_tdata[16*f +: 16]
                          : e[144 + 17*(f-9) +: 17] !== out_tdata[144 + 17*(f-9) +: 17])
                  $display("field %0d: expected %h got %h", f,
                           f < 9 ? e[16*f +: 16] : e[144 + 17*(f-9) +: 17],
                           f < 9 ? out_tdata[16*f +: 16] : out_tdata[144 + 17*(f-9) +: 17]);
          end
        end
      end
      if (idle_cycles > 40000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic add_set(int n, int mode);
    vertex_t v;
    for (int i = 0; i < n; i++) begin
      v.px = rand_coord(mode); v.py = rand_coord(mode); v.pz = rand_coord(mode);
      v.last = (i == n - 1);
      pending_verts = {pending_verts, v};
    end
  endtask

  initial begin
    vertex_t v;
    int sent;
    // directed: single vertex, extremes, mixed extremes, tiny values
    add_set(1, 0);
    add_set(1, 1);
    add_set(2, 2);
    for (int i = 0; i < 4; i++) begin
      v.px = i[0] ? 16'h7fff : 16'h8000; v.py = i[1] ? 16'h7fff : 16'h8000;
      v.pz = i[0] ? 16'h8000 : 16'h7fff; v.last = (i == 3);
      pending_verts = {pending_verts, v};
    end
    add_set(5, 3);
    add_set(3, 0);
    // over capacity, vertices past the limit ignored but the last still closes the set
    add_set(vbs_pkg::MAX_VERTICES + 3, 3);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    sent = 0;
    while (sent < 150) begin
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      add_set(n, $urandom_range(0, 9) < 1 ? $urandom_range(0, 2) : 3);
      sent += n;
    end
    wait (pending_verts.size() == 0 && !in_tvalid);
    wait (expected_stats.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
